/* design/ksd_pkg.sv */
// Shared types and codes for the key set sort/dedupe block.
// No dependencies; used by ksd_ctrl, ksd_datapath and the top level.
package ksd_pkg;
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_UNIQ   = 2'd1;
  localparam logic [1:0] FUNC_EMPTY  = 2'd2;

  localparam logic [1:0] ST_EMIT  = 2'd0;
  localparam logic [1:0] ST_DROP  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic append;     // write input key at count, bump count
    logic clear;      // zero the count
    logic sort_init;  // i = 1
    logic rd_start;   // start read of outer index i (sort pass)
    logic load_v;     // capture key[i] as v, set j = i
    logic rd_prev;    // read key[j-1]
    logic shift;      // key[j] = key[j-1], j--
    logic place;      // key[j] = v, i++
    logic dd_init;    // w = 0, r = 1, read key[0]
    logic dd_rd;      // read key[r]
    logic dd_step;    // compare and compact, r++
    logic dd_done;    // count = w + 1
    logic em_init;    // r = 0
    logic em_rd;      // read key[r]
    logic em_next;    // r++
  } ksd_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic full;       // count == capacity
    logic empty;      // count == 0
    logic i_done;     // i >= count
    logic j_zero;     // j == 0
    logic prev_gt;    // key[j-1] > v
    logic r_done;     // r >= count
    logic em_last;    // r + 1 == count
  } ksd_sts_t;
endpackage

/* design/key_set_sort_dedupe_top.sv */
// Key set sort/dedupe: append stores the key; drop and empty results are valid
// the cycle after the item. Uniq runs an insertion sort over one memory port,
// then a dedupe pass that compacts equal neighbours, then emits each kept key.
// Sequential: one item at a time. Synchronous active-high reset empties
// the table; stored key memory is not cleared.
module key_set_sort_dedupe_top #(
  parameter int TABLE_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // [1:0] func, [33:2] key_value, zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // [31:0] out_key, [38:32] unique_count, [40:39] status
  output logic        m_tlast
);
  import ksd_pkg::*;
  ksd_cmd_t cmd;
  ksd_sts_t sts;
  logic [31:0] rd_key, o_key;
  logic [6:0] count, o_cnt;
  logic [1:0] o_status;

  ksd_datapath #(.TABLE_CAPACITY(TABLE_CAPACITY)) u_dp (
    .clk, .rst, .cmd, .key_in(s_tdata[33:2]), .sts, .rd_key, .count
  );
  ksd_ctrl u_ctrl (
    .clk, .rst, .s_valid(s_tvalid), .s_ready(s_tready), .func(s_tdata[1:0]),
    .sts, .cmd, .rd_key, .count, .o_valid(m_tvalid), .o_ready(m_tready),
    .o_key, .o_cnt, .o_status, .o_last(m_tlast)
  );
  assign m_tdata = {7'd0, o_status, o_cnt, o_key};
endmodule

/* design/ksd_datapath.sv */
// Key store memory, index counters and compare logic for sort and dedupe.
// Depends on ksd_pkg; driven by ksd_ctrl.
module ksd_datapath #(
  parameter int TABLE_CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  ksd_pkg::ksd_cmd_t cmd,
  input  logic [31:0]       key_in,
  output ksd_pkg::ksd_sts_t sts,
  output logic [31:0]       rd_key,
  output logic [6:0]        count
);
  import ksd_pkg::*;
  localparam int AW = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
  localparam int CW = $clog2(TABLE_CAPACITY + 1);

  logic [31:0] mem [TABLE_CAPACITY];
  logic [31:0] rdata;
  logic [31:0] v;
  logic [31:0] wkey;
  logic [CW-1:0] cnt, i, j, r, w;
  logic [AW-1:0] raddr, waddr;
  logic [31:0] wdata;
  logic        we;

  // read address selection
  always_comb begin
    raddr = r[AW-1:0];
    if (cmd.rd_start) raddr = i[AW-1:0];
    else if (cmd.rd_prev) raddr = j[AW-1:0] - 1'b1;
    else if (cmd.dd_init) raddr = '0;
  end

  // write port selection
  always_comb begin
    we = 1'b0;
    waddr = cnt[AW-1:0];
    wdata = key_in;
    if (cmd.append) begin
      we = 1'b1;
    end else if (cmd.shift) begin
      we = 1'b1; waddr = j[AW-1:0]; wdata = rdata;
    end else if (cmd.place) begin
      we = 1'b1; waddr = j[AW-1:0]; wdata = v;
    end else if (cmd.dd_step && rdata != wkey) begin
      we = 1'b1; waddr = w[AW-1:0] + 1'b1; wdata = rdata;
    end
  end

  // memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // counters and held keys
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      if (cmd.append) cnt <= cnt + 1'b1;
      if (cmd.clear) cnt <= '0;
      if (cmd.dd_done) cnt <= w + 1'b1;
    end
    if (cmd.load_v) begin
      v <= rdata; j <= i;
    end
    if (cmd.shift) j <= j - 1'b1;
    if (cmd.place) i <= i + 1'b1;
    if (cmd.sort_init) i <= CW'(1);
    if (cmd.dd_init) begin
      w <= '0; r <= CW'(1);
    end
    if (cmd.dd_step) begin
      r <= r + 1'b1;
      if (rdata != wkey) begin
        w <= w + 1'b1; wkey <= rdata;
      end
    end
    // first dedupe read: key[0] is on the read port, keep it as last kept key
    if (cmd.dd_rd && r == CW'(1)) wkey <= rdata;
    if (cmd.em_init) r <= '0;
    if (cmd.em_next) r <= r + 1'b1;
  end

  assign sts.full    = (cnt == CW'(TABLE_CAPACITY));
  assign sts.empty   = (cnt == '0);
  assign sts.i_done  = (i >= cnt);
  assign sts.j_zero  = (j == '0);
  assign sts.prev_gt = (rdata > v);
  assign sts.r_done  = (r >= cnt);
  assign sts.em_last = (r + 1'b1 == cnt);
  assign rd_key = rdata;
  assign count  = 7'(cnt);
endmodule

/* design/ksd_ctrl.sv */
// Sequencer for append, insertion sort, dedupe and emit.
// Depends on ksd_pkg; commands ksd_datapath.
module ksd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  logic [1:0]        func,
  input  ksd_pkg::ksd_sts_t sts,
  output ksd_pkg::ksd_cmd_t cmd,
  input  logic [31:0]       rd_key,
  input  logic [6:0]        count,
  output logic              o_valid,
  input  logic              o_ready,
  output logic [31:0]       o_key,
  output logic [6:0]        o_cnt,
  output logic [1:0]        o_status,
  output logic              o_last
);
  import ksd_pkg::*;
  typedef enum logic [3:0] {
    IDLE, S_START, S_LOAD, S_RDP, S_CMP, DD_WAIT, DD_RD, DD_STEP,
    DD_DONE, EM_RD, EM_WAIT, EM_OUT, OUT_WAIT
  } state_t;
  state_t state;
  logic fire;

  assign s_ready = (state == IDLE) && !o_valid;
  assign fire = s_valid && s_ready;

  // command decode
  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: if (fire) begin
        cmd.append = (func == FUNC_APPEND) && !sts.full;
        cmd.clear  = (func == FUNC_EMPTY);
        if (func == FUNC_UNIQ && !sts.empty) cmd.sort_init = 1'b1;
      end
      S_START: cmd.rd_start = 1'b1;
      S_LOAD:  if (!sts.i_done) cmd.load_v = 1'b1;
      S_RDP:   if (sts.j_zero) cmd.place = 1'b1;
               else cmd.rd_prev = 1'b1;
      S_CMP:   if (sts.prev_gt) cmd.shift = 1'b1;
               else cmd.place = 1'b1;
      DD_WAIT: cmd.dd_init = 1'b1;
      DD_RD:   cmd.dd_rd = 1'b1;
      DD_STEP: cmd.dd_step = 1'b1;
      DD_DONE: begin
        cmd.dd_done = 1'b1;
        cmd.em_init = 1'b1;
      end
      EM_RD:   cmd.em_rd = 1'b1;
      default: ;
    endcase
    if (state == OUT_WAIT && o_valid && o_ready) cmd.em_next = 1'b1;
    if (state == IDLE && fire && func == FUNC_UNIQ) cmd.clear = 1'b0;
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE; o_valid <= 1'b0;
    end else begin
      if (o_valid && o_ready) o_valid <= 1'b0;
      unique case (state)
        IDLE: if (fire) begin
          if (func == FUNC_APPEND && sts.full) begin
            o_valid <= 1'b1; o_key <= '0; o_cnt <= count;
            o_status <= ST_DROP; o_last <= 1'b1;
          end else if (func == FUNC_UNIQ) begin
            if (sts.empty) begin
              o_valid <= 1'b1; o_key <= '0; o_cnt <= '0;
              o_status <= ST_EMPTY; o_last <= 1'b1;
            end else state <= S_START;
          end
        end
        S_START: state <= S_LOAD;
        S_LOAD: state <= sts.i_done ? DD_WAIT : S_RDP;
        S_RDP: state <= sts.j_zero ? S_START : S_CMP;
        S_CMP: state <= sts.prev_gt ? S_RDP : S_START;
        DD_WAIT: state <= DD_RD;
        DD_RD: state <= sts.r_done ? DD_DONE : DD_STEP;
        DD_STEP: state <= DD_RD;
        DD_DONE: state <= EM_RD;
        EM_RD: state <= EM_WAIT;
        EM_WAIT: state <= EM_OUT;
        EM_OUT: begin
          o_valid <= 1'b1; o_key <= rd_key; o_cnt <= count;
          o_status <= ST_EMIT; o_last <= sts.em_last;
          state <= OUT_WAIT;
        end
        OUT_WAIT: if (o_valid && o_ready) state <= o_last ? IDLE : EM_RD;
        default: state <= IDLE;
      endcase
    end
  end
endmodule

/* tb/tb_key_set_sort_dedupe_top.sv */
// Testbench for key_set_sort_dedupe_top: drives append/uniq/empty items and
// checks every emitted result against a behavioral key table. Needs ksd_pkg.
`timescale 1ns / 100ps

module tb_key_set_sort_dedupe_top;
  import ksd_pkg::*;

  localparam int CAP = 64;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [31:0] key;
    logic [6:0]  cnt;
    logic [1:0]  st;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;

  logic [39:0] pending_items[$];
  result_t     expected_results[$];
  logic [31:0] table_keys[CAP];
  int          table_count = 0;
  int          errors = 0;
  int          cycles = 0;
  bit          stall_free = 1'b0;
  bit          hold_sender = 1'b0;

  key_set_sort_dedupe_top #(.TABLE_CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // Apply one accepted item to the table and queue its results.
  task automatic predict_key_set(input logic [39:0] item);
    logic [1:0]  op;
    logic [31:0] k, v;
    int          j, w;
    op = item[1:0];
    k  = item[33:2];
    if (op == FUNC_APPEND) begin
      if (table_count < CAP) begin
        table_keys[table_count] = k;
        table_count++;
      end else begin
        expected_results.push_back('{32'd0, 7'(table_count), ST_DROP, 1'b1});
      end
    end else if (op == FUNC_EMPTY) begin
      table_count = 0;
    end else if (op == FUNC_UNIQ) begin
      if (table_count == 0) begin
        expected_results.push_back('{32'd0, 7'd0, ST_EMPTY, 1'b1});
      end else begin
        // insertion sort, then compact duplicates
        for (int a = 1; a < table_count; a++) begin
          v = table_keys[a];
          j = a;
          while (j > 0 && table_keys[j-1] > v) begin
            table_keys[j] = table_keys[j-1];
            j--;
          end
          table_keys[j] = v;
        end
        w = 0;
        for (int r = 1; r < table_count; r++) begin
          if (table_keys[r] != table_keys[w]) begin
            w++;
            table_keys[w] = table_keys[r];
          end
        end
        table_count = w + 1;
        for (int r = 0; r < table_count; r++)
          expected_results.push_back('{table_keys[r], 7'(table_count), ST_EMIT,
                                       (r + 1 == table_count)});
      end
    end
  endtask

  function automatic logic [39:0] make_item(input logic [1:0] op, input logic [31:0] k);
    return {6'd0, k, op};
  endfunction

  // Pick keys from a narrow pool now and then so duplicates are common.
  function automatic logic [31:0] rand_key(input int pool);
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, pool));
      1: return 32'hFFFF_FFFF - 32'($urandom_range(0, pool));
      default: return $urandom;
    endcase
  endfunction

  // Drive items from the pending queue; hold while the sender is paused.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_tready) begin
      // hold current item
    end else begin
      if (s_tvalid) begin
        predict_key_set(s_tdata);
        void'(pending_items.pop_front());
      end
      if (pending_items.size() > 0 && !hold_sender &&
          (stall_free || $urandom_range(0, 99) >= 30)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_items[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Check results and randomly stall the result side.
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_tdata));
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (m_tdata[31:0] !== e.key)
            report_mismatch($sformatf("out_key %h want %h", m_tdata[31:0], e.key));
          if (m_tdata[38:32] !== e.cnt)
            report_mismatch($sformatf("unique_count %0d want %0d", m_tdata[38:32], e.cnt));
          if (m_tdata[40:39] !== e.st)
            report_mismatch($sformatf("status %0d want %0d", m_tdata[40:39], e.st));
          if (m_tlast !== e.last)
            report_mismatch($sformatf("last %b want %b", m_tlast, e.last));
        end
      end
      m_tready <= stall_free || ($urandom_range(0, 99) >= 30);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_key_set_sort_dedupe_top: errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    logic [1:0] op;
    int         pool;
    int         n;
    // directed: empty uniq, single key, extremes, duplicates, unused function code
    pending_items.push_back(make_item(FUNC_UNIQ, 32'd0));
    pending_items.push_back(make_item(FUNC_APPEND, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(FUNC_UNIQ, 32'd0));
    pending_items.push_back(make_item(FUNC_APPEND, 32'd0));
    pending_items.push_back(make_item(FUNC_APPEND, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(FUNC_APPEND, 32'd0));
    pending_items.push_back(make_item(FUNC_APPEND, 32'hAAAA_5555));
    pending_items.push_back(make_item(2'd3, 32'h5555_AAAA));
    pending_items.push_back(make_item(FUNC_UNIQ, 32'h1234_5678));
    pending_items.push_back(make_item(FUNC_EMPTY, 32'd0));
    pending_items.push_back(make_item(FUNC_UNIQ, 32'd0));
    for (int i = 0; i < 4; i++)
      pending_items.push_back(make_item(FUNC_APPEND, 32'h77));
    pending_items.push_back(make_item(FUNC_UNIQ, 32'd0));
    pending_items.push_back(make_item(FUNC_EMPTY, 32'd0));
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    // fill past capacity in descending order to exercise drops and a long sort
    for (int i = 0; i < CAP + 2; i++)
      pending_items.push_back(make_item(FUNC_APPEND, 32'(CAP - i) * 32'h0101_0101));
    pending_items.push_back(make_item(FUNC_UNIQ, 32'd0));
    pending_items.push_back(make_item(FUNC_EMPTY, 32'd0));
    wait_drained();

    // random runs: appends of random content, then uniq, sometimes empty
    n = 0;
    while (n < 280) begin
      pool = $urandom_range(0, 1) ? 7 : 1000;
      repeat ($urandom_range(0, 12)) begin
        op = FUNC_APPEND;
        if ($urandom_range(0, 19) == 0) op = 2'($urandom_range(0, 3));
        pending_items.push_back(make_item(op, rand_key(pool)));
        n++;
      end
      pending_items.push_back(make_item(FUNC_UNIQ, $urandom));
      n++;
      if ($urandom_range(0, 3) == 0) begin
        pending_items.push_back(make_item(FUNC_EMPTY, $urandom));
        n++;
      end
      if (n > 140 && n < 170) stall_free = 1'b1;
      else stall_free = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        // pause the sender until every result has come back
        hold_sender = 1'b1;
        while (s_tvalid || expected_results.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      while (pending_items.size() > 8) @(posedge clk);
    end
    wait_drained();
    repeat (CAP * CAP * 4) @(posedge clk);

    if (errors == 0) begin
      $display("tb_key_set_sort_dedupe_top: clean");
    end else begin
      $display("tb_key_set_sort_dedupe_top: errors");
    end
    $finish;
  end
endmodule

/* files.f */
design/ksd_pkg.sv
design/ksd_datapath.sv
design/ksd_ctrl.sv
design/key_set_sort_dedupe_top.sv
tb/tb_key_set_sort_dedupe_top.sv
